// File: src/sls_pkg.sv
// Shared constants and codes for the slot lane scheduler.
package sls_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int KEY_BITS  = 8;
  localparam int SEQ_BITS  = 32;

  localparam int PTR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAITER_CAP = 2'd1;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FIND  = 2'd1;
  localparam logic [1:0] MODE_ADMIT = 2'd2;
  localparam logic [1:0] MODE_NEXT  = 2'd3;

  localparam logic [1:0] ADM_START  = 2'd0;
  localparam logic [1:0] ADM_WAIT   = 2'd1;
  localparam logic [1:0] ADM_REJECT = 2'd2;

endpackage

// File: src/slot_lane_scheduler.sv
// Job slot table with per-key lanes: record writes, free-slot search, admission, next waiter.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: mode, slot_index,
//   internal_request and the new_* record fields. The output channel
//   (out_valid/out_ready) returns one result word per request: found,
//   result_slot, admission, waiters. The config channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes the user slot count (index 0) and the waiter
//   cap (index 1); it is always ready, and other indexes are dropped.
//   A slot write (mode 0) needs no scan. Modes 1, 2 and 3 scan the table one
//   slot per cycle through one shared compare unit (key match, lane-holder
//   check, sequence compare) before the result moves toward out_valid.
//   One request is in work at a time; in_ready rises right after the result
//   moves into the output register.
//   If the receiver stalls, the finished word holds in the output register and
//   the next request may be accepted and scanned meanwhile; its result then
//   waits until the output register drains, and in_ready stays low.
//   Reset clears all slot flags and keys, loads 12 user slots and a waiter
//   cap of 4, and empties the output register.
module slot_lane_scheduler
  import sls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [3:0]            slot_index,
  input  logic                  internal_request,
  input  logic                  new_allocated,
  input  logic                  new_active,
  input  logic                  new_started,
  input  logic                  new_waiting,
  input  logic [7:0]            new_key,
  input  logic [31:0]           new_sequence,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [3:0]            result_slot,
  output logic [1:0]            admission,
  output logic [3:0]            waiters,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // Slot table
  logic [NUM_SLOTS-1:0] slot_allocated;
  logic [NUM_SLOTS-1:0] slot_active;
  logic [NUM_SLOTS-1:0] slot_started;
  logic [NUM_SLOTS-1:0] slot_waiting;
  logic [KEY_BITS-1:0]  slot_key      [NUM_SLOTS];
  logic [SEQ_BITS-1:0]  slot_sequence [NUM_SLOTS];

  logic [4:0] user_slots;
  logic [4:0] waiter_cap;

  // Request context latched at acceptance
  logic [1:0]          op_mode;
  logic                op_internal;
  logic [PTR_W-1:0]    cand;
  logic                cand_ok;
  logic [KEY_BITS-1:0] cand_key;

  // Scan pointer and accumulators
  logic [PTR_W-1:0]    ptr;
  logic                acc_found;
  logic [PTR_W-1:0]    acc_slot;
  logic [SEQ_BITS-1:0] acc_seq;
  logic                int_found;
  logic [PTR_W-1:0]    int_slot;
  logic [CNT_W-1:0]    cnt;
  logic                lane;

  logic                acc_found_next;
  logic [PTR_W-1:0]    acc_slot_next;
  logic [SEQ_BITS-1:0] acc_seq_next;
  logic                int_found_next;
  logic [PTR_W-1:0]    int_slot_next;
  logic [CNT_W-1:0]    cnt_next;
  logic                lane_next;

  // Finished result, waiting for the output register
  logic       res_found;
  logic [3:0] res_slot;
  logic [1:0] res_adm;
  logic [3:0] res_wait;

  logic       fin_found;
  logic [3:0] fin_slot;
  logic [1:0] fin_adm;
  logic [3:0] fin_wait;

  // Shared compare unit signals
  logic [NUM_SLOTS-1:0] holder;
  logic [KEY_BITS-1:0]  key_p;
  logic                 busy_p;
  logic                 cand_match;
  logic                 in_internal;
  logic                 eligible;

  logic                 in_fire;
  logic                 in_range;
  logic [PTR_W-1:0]     in_slot;
  logic                 last;
  logic                 out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_range  = (int'(slot_index) < NUM_SLOTS);
  assign in_slot   = PTR_W'(slot_index);
  assign last      = (ptr == PTR_W'(NUM_SLOTS - 1));
  assign out_free  = !out_valid || out_ready;

  // Lane holders: allocated, active and started
  assign holder = slot_allocated & slot_active & slot_started;
  assign key_p  = slot_key[ptr];

  // Lane-busy check for the slot under the pointer, against every other slot
  always_comb begin
    busy_p = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if ((PTR_W'(i) != ptr) && holder[i] && (slot_key[i] == key_p)) begin
        busy_p = 1'b1;
      end
    end
    busy_p = busy_p && (key_p != '0);
  end

  assign cand_match = (ptr != cand) && slot_allocated[ptr] && slot_active[ptr] &&
                      (key_p == cand_key);
  assign in_internal = (int'(ptr) >= int'(user_slots));
  assign eligible    = slot_allocated[ptr] && slot_active[ptr] && slot_waiting[ptr] &&
                       !busy_p;

  // Accumulator update for one scan step
  always_comb begin
    acc_found_next = acc_found;
    acc_slot_next  = acc_slot;
    acc_seq_next   = acc_seq;
    int_found_next = int_found;
    int_slot_next  = int_slot;
    cnt_next       = cnt;
    lane_next      = lane;
    case (op_mode)
      MODE_FIND: begin
        // Lowest free slot in each region
        if (!slot_allocated[ptr]) begin
          if (in_internal) begin
            if (!int_found) begin
              int_found_next = 1'b1;
              int_slot_next  = ptr;
            end
          end else if (!acc_found) begin
            acc_found_next = 1'b1;
            acc_slot_next  = ptr;
          end
        end
      end
      MODE_ADMIT: begin
        if (cand_match && slot_waiting[ptr]) begin
          cnt_next = cnt + CNT_W'(1);
        end
        if (cand_match && slot_started[ptr]) begin
          lane_next = 1'b1;
        end
      end
      MODE_NEXT: begin
        // Strictly older wins, so ties stay with the lower index
        if (eligible && (!acc_found || (slot_sequence[ptr] < acc_seq))) begin
          acc_found_next = 1'b1;
          acc_slot_next  = ptr;
          acc_seq_next   = slot_sequence[ptr];
        end
      end
      default: begin
      end
    endcase
  end

  // Result from the accumulators after the final scan step
  always_comb begin
    fin_found = 1'b0;
    fin_slot  = '0;
    fin_adm   = ADM_START;
    fin_wait  = '0;
    case (op_mode)
      MODE_FIND: begin
        if (int'(user_slots) <= NUM_SLOTS) begin
          if (op_internal && int_found_next) begin
            fin_found = 1'b1;
            fin_slot  = 4'(int_slot_next);
          end else if (acc_found_next) begin
            fin_found = 1'b1;
            fin_slot  = 4'(acc_slot_next);
          end
        end
      end
      MODE_ADMIT: begin
        if (!cand_ok) begin
          fin_adm = ADM_REJECT;
        end else if (cand_key != '0) begin
          fin_wait = (int'(cnt_next) > 15) ? 4'd15 : 4'(cnt_next);
          if (!lane_next && (cnt_next == '0)) begin
            fin_adm = ADM_START;
          end else if (int'(cnt_next) >= int'(waiter_cap)) begin
            fin_adm = ADM_REJECT;
          end else begin
            fin_adm = ADM_WAIT;
          end
        end
      end
      MODE_NEXT: begin
        fin_found = acc_found_next;
        fin_slot  = acc_found_next ? 4'(acc_slot_next) : 4'd0;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      user_slots <= 5'd12;
      waiter_cap <= 5'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_USER_SLOTS: user_slots <= 5'(cfg_data);
        CFG_WAITER_CAP: waiter_cap <= 5'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Slot flags and keys; a write request updates one record
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_allocated <= '0;
      slot_active    <= '0;
      slot_started   <= '0;
      slot_waiting   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_key[i] <= '0;
      end
    end else if (in_fire && (mode == MODE_WRITE) && in_range) begin
      slot_allocated[in_slot] <= new_allocated;
      slot_active[in_slot]    <= new_active;
      slot_started[in_slot]   <= new_started;
      slot_waiting[in_slot]   <= new_waiting;
      slot_key[in_slot]       <= KEY_BITS'(new_key);
    end
  end

  // Sequence numbers are only read for allocated slots
  always_ff @(posedge clk) begin
    if (in_fire && (mode == MODE_WRITE) && in_range) begin
      slot_sequence[in_slot] <= SEQ_BITS'(new_sequence);
    end
  end

  // Sequencer, scan accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the drained word unless a new one loads in this cycle
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_mode     <= mode;
            op_internal <= internal_request;
            cand        <= in_slot;
            cand_ok     <= in_range;
            cand_key    <= slot_key[in_slot];
            ptr         <= '0;
            acc_found   <= 1'b0;
            acc_slot    <= '0;
            acc_seq     <= '0;
            int_found   <= 1'b0;
            int_slot    <= '0;
            cnt         <= '0;
            lane        <= 1'b0;
            if (mode == MODE_WRITE) begin
              res_found <= in_range;
              res_slot  <= in_range ? slot_index : 4'd0;
              res_adm   <= ADM_START;
              res_wait  <= '0;
              state     <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          acc_found <= acc_found_next;
          acc_slot  <= acc_slot_next;
          acc_seq   <= acc_seq_next;
          int_found <= int_found_next;
          int_slot  <= int_slot_next;
          cnt       <= cnt_next;
          lane      <= lane_next;
          ptr       <= ptr + PTR_W'(1);
          if (last) begin
            res_found <= fin_found;
            res_slot  <= fin_slot;
            res_adm   <= fin_adm;
            res_wait  <= fin_wait;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_valid   <= 1'b1;
            found       <= res_found;
            result_slot <= res_slot;
            admission   <= res_adm;
            waiters     <= res_wait;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: bench/sls_reply_check.sv
// Reply checker for the slot lane scheduler: tracks the slot table and compares every result word.
module sls_reply_check
  import sls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [3:0]            slot_index,
  input  logic                  internal_request,
  input  logic                  new_allocated,
  input  logic                  new_active,
  input  logic                  new_started,
  input  logic                  new_waiting,
  input  logic [7:0]            new_key,
  input  logic [31:0]           new_sequence,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  found,
  input  logic [3:0]            result_slot,
  input  logic [1:0]            admission,
  input  logic [3:0]            waiters,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    open_replies,
  output int                    fail_count
);

  localparam logic [CFG_DATA_W-1:0] USER_SLOTS_RST = 5'd12;
  localparam logic [CFG_DATA_W-1:0] WAITER_CAP_RST = 5'd4;
  // keep the log readable when the block is badly off
  localparam int REPORT_LIMIT = 60;

  typedef struct packed {
    logic [1:0]          mode;
    logic [3:0]          slot;
    logic                internal;
    logic                allocated;
    logic                active;
    logic                started;
    logic                waiting;
    logic [KEY_BITS-1:0] key;
    logic [SEQ_BITS-1:0] seq;
  } request_t;

  typedef struct packed {
    logic       found;
    logic [3:0] slot;
    logic [1:0] admission;
    logic [3:0] waiters;
  } reply_t;

  logic [NUM_SLOTS-1:0] slot_used;
  logic [NUM_SLOTS-1:0] slot_live;
  logic [NUM_SLOTS-1:0] slot_running;
  logic [NUM_SLOTS-1:0] slot_parked;
  logic [KEY_BITS-1:0]  slot_lane  [NUM_SLOTS];
  logic [SEQ_BITS-1:0]  slot_order [NUM_SLOTS];
  logic [CFG_DATA_W-1:0] user_slots;
  logic [CFG_DATA_W-1:0] waiter_cap;

  reply_t replies_due [$];

  function automatic logic lane_taken(int c);
    if (slot_lane[c] == '0) return 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (i != c && slot_used[i] && slot_live[i] && slot_running[i] &&
          slot_lane[i] == slot_lane[c])
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic int waiters_on_lane(int c);
    int n;
    n = 0;
    if (slot_lane[c] == '0) return 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (i != c && slot_used[i] && slot_live[i] && slot_parked[i] &&
          slot_lane[i] == slot_lane[c])
        n++;
    return n;
  endfunction

  // Apply one request to the table copy and return the word it should produce.
  function automatic reply_t compute_reply(request_t rq);
    reply_t rp;
    int     w;
    rp = '0;
    case (rq.mode)
      MODE_WRITE: begin
        slot_used[rq.slot]    = rq.allocated;
        slot_live[rq.slot]    = rq.active;
        slot_running[rq.slot] = rq.started;
        slot_parked[rq.slot]  = rq.waiting;
        slot_lane[rq.slot]    = rq.key;
        slot_order[rq.slot]   = rq.seq;
        rp.found = 1'b1;
        rp.slot  = rq.slot;
      end
      MODE_FIND: begin
        if (user_slots <= NUM_SLOTS) begin
          if (rq.internal)
            for (int i = int'(user_slots); i < NUM_SLOTS; i++)
              if (!rp.found && !slot_used[i]) begin
                rp.found = 1'b1;
                rp.slot  = 4'(i);
              end
          for (int i = 0; i < int'(user_slots); i++)
            if (!rp.found && !slot_used[i]) begin
              rp.found = 1'b1;
              rp.slot  = 4'(i);
            end
        end
      end
      MODE_ADMIT: begin
        if (slot_lane[rq.slot] == '0) begin
          rp.admission = ADM_START;
        end else begin
          w = waiters_on_lane(int'(rq.slot));
          rp.waiters = (w > 15) ? 4'd15 : 4'(w);
          if (!lane_taken(int'(rq.slot)) && w == 0)
            rp.admission = ADM_START;
          else
            rp.admission = (w >= int'(waiter_cap)) ? ADM_REJECT : ADM_WAIT;
        end
      end
      default: begin
        // oldest runnable waiter; strict compare keeps the lower index on a tie
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_used[i] || !slot_live[i] || !slot_parked[i] || lane_taken(i))
            continue;
          if (!rp.found || slot_order[i] < slot_order[rp.slot]) begin
            rp.found = 1'b1;
            rp.slot  = 4'(i);
          end
        end
      end
    endcase
    return rp;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    request_t rq;
    reply_t   want;
    if (rst) begin
      slot_used    = '0;
      slot_live    = '0;
      slot_running = '0;
      slot_parked  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_lane[i]  = '0;
        slot_order[i] = '0;
      end
      user_slots = USER_SLOTS_RST;
      waiter_cap = WAITER_CAP_RST;
      fail_count = 0;
      replies_due.delete();
      open_replies <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_USER_SLOTS)
          user_slots = cfg_data;
        else if (cfg_index == CFG_WAITER_CAP)
          waiter_cap = cfg_data;
      end
      // check the outgoing word before queuing a new one: no reply leaves in the same cycle as its request
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t unexpected word: expected none, got slot %0d", $time,
                     result_slot);
        end else begin
          want = replies_due.pop_front();
          check_field("found", want.found, found);
          check_field("result_slot", want.slot, result_slot);
          check_field("admission", want.admission, admission);
          check_field("waiters", want.waiters, waiters);
        end
      end
      if (in_valid && in_ready) begin
        rq.mode      = mode;
        rq.slot      = slot_index;
        rq.internal  = internal_request;
        rq.allocated = new_allocated;
        rq.active    = new_active;
        rq.started   = new_started;
        rq.waiting   = new_waiting;
        rq.key       = new_key;
        rq.seq       = new_sequence;
        replies_due.push_back(compute_reply(rq));
      end
      open_replies <= replies_due.size();
    end
  end

endmodule

// File: bench/tb_slot_lane_scheduler.sv
// Testbench top for the slot lane scheduler: stimulus, back-pressure and verdict.
module tb_slot_lane_scheduler
  import sls_pkg::*;
();

  // Slowest legal run is roughly 1500 words; allow far more.
  localparam int RUN_LIMIT    = 300000;
  // scan latency plus margin, used after the table has drained
  localparam int DRAIN_CYCLES = NUM_SLOTS + 6;
  // long receiver hold-off that fills the output register and the scan slot
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 160;
  // index that decodes to no register; the block must drop it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst              = 1'b1;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic [1:0]            mode             = MODE_WRITE;
  logic [3:0]            slot_index       = '0;
  logic                  internal_request = 1'b0;
  logic                  new_allocated    = 1'b0;
  logic                  new_active       = 1'b0;
  logic                  new_started      = 1'b0;
  logic                  new_waiting      = 1'b0;
  logic [7:0]            new_key          = '0;
  logic [31:0]           new_sequence     = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic                  found;
  logic [3:0]            result_slot;
  logic [1:0]            admission;
  logic [3:0]            waiters;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  int open_replies;
  int fail_count;
  int cycle_count;
  int items_sent  = 0;
  int words_taken = 0;

  // keys shared by the random writes of one phase, so lanes collide often
  logic [7:0] lane_pool [4];
  int         pool_size = 1;

  slot_lane_scheduler i_dut (.*);

  sls_reply_check i_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: counts cycles and ends a run that hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one request word and hold it until the block takes it. Bursts of
  // back-to-back words alternate with random gaps, so gaps land anywhere in a scan.
  task automatic send_word(input logic [1:0] m, input logic [3:0] s, input logic intr,
                           input logic [3:0] flags, input logic [7:0] k,
                           input logic [31:0] q);
    int gap;
    gap = (items_sent % 200 < 40) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    mode             <= m;
    slot_index       <= s;
    internal_request <= intr;
    {new_allocated, new_active, new_started, new_waiting} <= flags;
    new_key          <= k;
    new_sequence     <= q;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Query word: fill the record fields with noise, the block must ignore them.
  task automatic ask(input logic [1:0] m, input logic [3:0] s, input logic intr);
    send_word(m, s, intr, 4'($urandom), 8'($urandom), $urandom);
  endtask

  // Slot write: internal_request carries noise.
  task automatic put_slot(input logic [3:0] s, input logic [3:0] flags,
                          input logic [7:0] k, input logic [31:0] q);
    send_word(MODE_WRITE, s, 1'($urandom), flags, k, q);
  endtask

  // Drop valid, wait for every expected word, then let any scan finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_replies != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, optionally preceded by a dropped index.
  task automatic program_regs(input logic [4:0] cap, input logic [4:0] lim,
                              input bit spare);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] dat [3];
    int n;
    n = 0;
    if (spare) begin
      idx[n] = CFG_SPARE;
      dat[n] = 5'($urandom);
      n++;
    end
    idx[n] = CFG_USER_SLOTS;
    dat[n] = cap;
    n++;
    idx[n] = CFG_WAITER_CAP;
    dat[n] = lim;
    n++;
    cfg_valid <= 1'b1;
    for (int j = 0; j < n; j++) begin
      cfg_index <= idx[j];
      cfg_data  <= dat[j];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly coherent table traffic: writes that reuse a few lane keys with
  // likely allocated/active flags, mixed with queries; a tenth is noise.
  task automatic random_word();
    int          pick;
    logic [1:0]  m;
    logic [3:0]  flags;
    logic [7:0]  k;
    logic [31:0] q;
    pick  = $urandom_range(0, 99);
    flags = {1'($urandom_range(0, 9) < 8), 1'($urandom_range(0, 9) < 8),
             1'($urandom_range(0, 9) < 3), 1'($urandom_range(0, 1))};
    if ($urandom_range(0, 9) == 0)
      flags = 4'($urandom);
    case ($urandom_range(0, 9))
      0:       k = '0;
      1:       k = 8'($urandom);
      default: k = lane_pool[$urandom_range(0, pool_size - 1)];
    endcase
    // small sequence numbers make ties between waiters common
    q = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : $urandom;
    if (pick < 45)
      m = MODE_WRITE;
    else if (pick < 60)
      m = MODE_FIND;
    else if (pick < 80)
      m = MODE_ADMIT;
    else
      m = MODE_NEXT;
    send_word(m, 4'($urandom), 1'($urandom), flags, k, q);
  endtask

  // Receiver: random stalls per word with stall-free stretches, plus two long
  // hold-offs while the sender keeps offering, so the block stalls its input.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = (words_taken % 170 < 30) ? 0 : $urandom_range(0, 4);
      if (words_taken == 150 || words_taken == 900)
        stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words_taken++;
    end
  end

  initial begin
    logic [4:0] caps   [9];
    logic [4:0] limits [9];
    caps   = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd17, 5'd8, 5'($urandom), 5'd16, 5'd1};
    limits = '{5'd0, 5'd16, 5'd31, 5'd2, 5'd1, 5'd3, 5'($urandom), 5'd0, 5'd15};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings (12 user slots, limit 4).
    ask(MODE_FIND, 4'd0, 1'b0);                 // empty table: user slot 0
    ask(MODE_FIND, 4'd0, 1'b1);                 // internal: first slot above capacity
    ask(MODE_NEXT, 4'd0, 1'b0);                 // nothing waiting
    ask(MODE_ADMIT, 4'd0, 1'b0);                // key 0 always starts
    put_slot(4'd15, 4'b1110, 8'hFF, 32'hFFFF_FFFF);
    put_slot(4'd0, 4'b1101, 8'hFF, 32'd0);
    put_slot(4'd1, 4'b1101, 8'hFF, 32'd5);
    put_slot(4'd2, 4'b1101, 8'h01, 32'd7);
    put_slot(4'd3, 4'b1101, 8'h01, 32'd7);
    ask(MODE_ADMIT, 4'd0, 1'b0);                // lane held, one waiter: wait
    ask(MODE_NEXT, 4'd0, 1'b0);                 // equal sequences: lower index wins
    ask(MODE_ADMIT, 4'd15, 1'b0);               // lane free but waiters present
    ask(MODE_ADMIT, 4'd2, 1'b0);
    put_slot(4'd12, 4'b1000, 8'h00, 32'd0);
    put_slot(4'd13, 4'b1000, 8'h00, 32'd0);
    put_slot(4'd14, 4'b1000, 8'h00, 32'd0);
    ask(MODE_FIND, 4'd0, 1'b1);                 // internal slots full: fall back to user
    ask(MODE_FIND, 4'd0, 1'b0);
    put_slot(4'd5, 4'b0011, 8'hAA, 32'h8000_0000);
    ask(MODE_ADMIT, 4'd5, 1'b0);                // own flags ignored, lone key starts
    put_slot(4'd4, 4'b1110, 8'h01, 32'd3);
    ask(MODE_ADMIT, 4'd3, 1'b0);                // lane now held by slot 4
    ask(MODE_NEXT, 4'd0, 1'b0);                 // every waiter blocked: none
    put_slot(4'd0, 4'b0000, 8'h00, 32'd0);

    // Random phases: capacity at zero, at the table size and beyond it,
    // limits at zero and at their top, with fresh lane keys each time.
    for (int p = 0; p < 9; p++) begin
      settle();
      program_regs(caps[p], limits[p], p == 2);
      pool_size = $urandom_range(1, 4);
      for (int j = 0; j < 4; j++)
        lane_pool[j] = 8'($urandom_range(1, 255));
      repeat (PHASE_WORDS) random_word();
    end

    settle();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
